// ===== rtl/capb_pkg.sv =====
// Shared types, constants and helpers for the client allowlist with port binding.
// No dependencies; imported by the queue, front, engine, top level and testbench.
`default_nettype none

package capb_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_CHECK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_SHIFT,
		ST_BIND,
		ST_RESP
	} back_state_t;

	localparam logic [31:0] MASK_8  = 32'hFF00_0000;
	localparam logic [31:0] MASK_12 = 32'hFFF0_0000;
	localparam logic [31:0] MASK_16 = 32'hFFFF_0000;
	localparam logic [31:0] NET_LOOPBACK = 32'h7F00_0000;
	localparam logic [31:0] NET_10      = 32'h0A00_0000;
	localparam logic [31:0] NET_172_16  = 32'hAC10_0000;
	localparam logic [31:0] NET_192_168 = 32'hC0A8_0000;

	typedef struct packed {
		op_t         op;
		logic [31:0] player_id;
		logic [31:0] address;
		logic [15:0] port;
		logic        private_addr;
	} item_t;

	typedef struct packed {
		logic [31:0] ident;
		logic [31:0] addr;
		logic [15:0] port;
	} entry_t;

	typedef struct packed {
		logic allowed;
		logic bound_now;
		logic private_addr;
		logic forward;
		logic table_full;
	} result_t;

	function automatic logic is_private(input logic [31:0] a);
		return ((a & MASK_8) == NET_LOOPBACK) ||
			((a & MASK_8) == NET_10) ||
			((a & MASK_12) == NET_172_16) ||
			((a & MASK_16) == NET_192_168);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/capb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module capb_ram #(
	parameter int WIDTH  = 80,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/capb_queue.sv =====
// Two-entry queue of classified words between the front and the back.
// Depends on capb_pkg for the item type.
`default_nettype none

module capb_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire capb_pkg::item_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output capb_pkg::item_t      pop_data
);
	import capb_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_fire;
	logic       pop_fire;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push_fire} - {1'b0, pop_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/capb_front.sv =====
// Input stage: takes words, decodes the operation and flags private addresses of check words.
// Depends on capb_pkg for the item type and the address classifier.
`default_nettype none

module capb_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] player_id,
	input  wire logic [31:0] address,
	input  wire logic [15:0] port,
	output logic             push_valid,
	input  wire logic        push_ready,
	output capb_pkg::item_t  push_data
);
	import capb_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	always_comb begin
		item_d.op           = op_t'(op);
		item_d.player_id    = player_id;
		item_d.address      = address;
		item_d.port         = port;
		item_d.private_addr = (op_t'(op) == OP_CHECK) && is_private(address);
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/capb_back.sv =====
// Execution engine: owns the entry table and count, scans entries one per cycle.
// Depends on capb_pkg and capb_ram.
`default_nettype none

module capb_back #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire capb_pkg::item_t pop_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output capb_pkg::result_t    out_data
);
	import capb_pkg::*;

	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ENTRY_W = $bits(entry_t);

	back_state_t state_q, state_d;
	item_t       item_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
	logic              pend_q, pend_d;
	logic [ADDR_W-1:0] pend_idx_q, pend_idx_d;
	logic              free_q, free_d;
	logic [ADDR_W-1:0] free_idx_q, free_idx_d;
	logic [31:0]       free_ident_q, free_ident_d;
	result_t           res_q, res_d;
	logic              oval_q, oval_d;
	result_t           odata_q, odata_d;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	entry_t             ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	logic               issue;

	capb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry  = entry_t'(ram_rdata);
	assign issue     = (rd_idx_q < n_q);
	assign out_valid = oval_q;
	assign out_data  = odata_q;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rd_idx_d     = rd_idx_q;
		pend_d       = 1'b0;
		pend_idx_d   = pend_idx_q;
		free_d       = free_q;
		free_idx_d   = free_idx_q;
		free_ident_d = free_ident_q;
		res_d        = res_q;
		oval_d       = oval_q;
		odata_d      = odata_q;
		ram_we       = 1'b0;
		ram_waddr    = count_q[ADDR_W-1:0];
		ram_wdata    = '0;
		ram_raddr    = rd_idx_q[ADDR_W-1:0];
		pop_ready    = 1'b0;

		if (oval_q && out_ready) begin
			oval_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				rd_idx_d = '0;
				free_d   = 1'b0;
				res_d    = '0;
				case (item_q.op)
					OP_ADD: begin
						if (count_q == CNT_W'(MAX_ENTRIES)) begin
							res_d.table_full = 1'b1;
						end else begin
							ram_we          = 1'b1;
							ram_waddr       = count_q[ADDR_W-1:0];
							ram_wdata.ident = item_q.player_id;
							ram_wdata.addr  = item_q.address;
							ram_wdata.port  = '0;
							count_d         = count_q + 1'b1;
						end
						state_d = ST_RESP;
					end
					OP_CLEAR: begin
						count_d = '0;
						state_d = ST_RESP;
					end
					default: begin
						state_d = ST_SCAN;
					end
				endcase
			end
			ST_SCAN: begin
				pend_d     = issue;
				pend_idx_d = rd_idx_q[ADDR_W-1:0];
				rd_idx_d   = rd_idx_q + CNT_W'(issue);
				if (item_q.op == OP_REMOVE) begin
					if (pend_q && rd_entry.ident == item_q.player_id) begin
						state_d = ST_SHIFT;
					end else if (!pend_q && !issue) begin
						state_d = ST_RESP;
					end
				end else if (pend_q && rd_entry.addr == item_q.address &&
						rd_entry.port == item_q.port) begin
					res_d.allowed = 1'b1;
					state_d       = ST_RESP;
				end else begin
					if (pend_q && rd_entry.addr == item_q.address && rd_entry.port == '0) begin
						free_d       = 1'b1;
						free_idx_d   = pend_idx_q;
						free_ident_d = rd_entry.ident;
					end
					if (!pend_q && !issue) begin
						state_d = free_q ? ST_BIND : ST_RESP;
					end
				end
			end
			ST_SHIFT: begin
				pend_d     = issue;
				pend_idx_d = rd_idx_q[ADDR_W-1:0];
				rd_idx_d   = rd_idx_q + CNT_W'(issue);
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = pend_idx_q - 1'b1;
					ram_wdata = rd_entry;
				end else if (!issue) begin
					count_d = n_q - 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_BIND: begin
				ram_we          = 1'b1;
				ram_waddr       = free_idx_q;
				ram_wdata.ident = free_ident_q;
				ram_wdata.addr  = item_q.address;
				ram_wdata.port  = item_q.port;
				res_d.allowed   = 1'b1;
				res_d.bound_now = 1'b1;
				state_d         = ST_RESP;
			end
			ST_RESP: begin
				if (!oval_q || out_ready) begin
					oval_d               = 1'b1;
					odata_d              = res_q;
					odata_d.private_addr = item_q.private_addr;
					odata_d.forward      = res_q.allowed || item_q.private_addr;
					state_d              = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			free_q  <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			free_q  <= free_d;
			oval_q  <= oval_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			item_q <= pop_data;
			n_q    <= count_q;
		end
		rd_idx_q     <= rd_idx_d;
		pend_idx_q   <= pend_idx_d;
		free_idx_q   <= free_idx_d;
		free_ident_q <= free_ident_d;
		res_q        <= res_d;
		odata_q      <= odata_d;
	end

endmodule

`default_nettype wire

// ===== rtl/client_allowlist_port_binding.sv =====
// Top level of the client allowlist with port binding.
// Depends on capb_pkg, capb_front, capb_queue and capb_back.
//
//   channel | direction | handshake           | fields
//   in      | input     | in_valid / in_ready   | op, player_id, address, port
//   out     | output    | out_valid / out_ready | allowed, bound_now, private_addr,
//           |           |                       | forward, table_full
//
// Add and clear go from the start state straight to the response state; remove
// and check scan the table through the single read port of the entry memory,
// one entry per cycle. Words pass the front register and queue before the engine.
// Reset empties the table at once; entries are never read at or above the count.
// A stalled output holds the engine in its response state; front and queue fill up.
`default_nettype none

module client_allowlist_port_binding #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] player_id,
	input  wire logic [31:0] address,
	input  wire logic [15:0] port,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             allowed,
	output logic             bound_now,
	output logic             private_addr,
	output logic             forward,
	output logic             table_full
);
	import capb_pkg::*;

	logic    push_valid;
	logic    push_ready;
	item_t   push_data;
	logic    pop_valid;
	logic    pop_ready;
	item_t   pop_data;
	result_t res;

	capb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.player_id (player_id),
		.address   (address),
		.port      (port),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	capb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	capb_back #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (res)
	);

	assign allowed      = res.allowed;
	assign bound_now    = res.bound_now;
	assign private_addr = res.private_addr;
	assign forward      = res.forward;
	assign table_full   = res.table_full;

endmodule

`default_nettype wire

// ===== rtl/capb_checker.sv =====
// Port-level checks for the client allowlist with port binding.
// Watches the top level's ports only; bound to the top level below.
`default_nettype none

module capb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic allowed,
	input wire logic bound_now,
	input wire logic private_addr,
	input wire logic forward,
	input wire logic table_full
);

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result word shown during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable({allowed, bound_now, private_addr, forward, table_full}))
		else $error("result word changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (allowed || bound_now || private_addr) |->
		forward && !table_full && (allowed || !bound_now))
		else $error("inconsistent result flags");

endmodule

bind client_allowlist_port_binding capb_checker u_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for client_allowlist_port_binding: directed and random add, remove, clear and
// check words, with results checked against an in-bench allowlist predictor.
// Depends on capb_pkg and the RTL of client_allowlist_port_binding.
module tb_top;
	import capb_pkg::*;

	localparam int TABLE_DEPTH = 32;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_CLEAR;
	logic [31:0] player_id = '0;
	logic [31:0] address = '0;
	logic [15:0] port = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        allowed;
	logic        bound_now;
	logic        private_addr;
	logic        forward;
	logic        table_full;

	logic [31:0] tab_ident [TABLE_DEPTH];
	logic [31:0] tab_addr [TABLE_DEPTH];
	logic [15:0] tab_port [TABLE_DEPTH];
	int          tab_count = 0;

	result_t     verdict_q [$];
	int          fault_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	client_allowlist_port_binding #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.player_id(player_id),
		.address(address),
		.port(port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.allowed(allowed),
		.bound_now(bound_now),
		.private_addr(private_addr),
		.forward(forward),
		.table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic in_private_range(logic [31:0] a);
		return a[31:24] == 8'd127 || a[31:24] == 8'd10 ||
			a[31:20] == 12'hAC1 || a[31:16] == 16'hC0A8;
	endfunction

	function automatic result_t allowlist_apply(op_t o, logic [31:0] id, logic [31:0] a,
			logic [15:0] p);
		result_t r;
		int i;
		int hit;
		int free_idx;
		r = '0;
		hit = -1;
		free_idx = -1;
		case (o)
		OP_ADD: begin
			if (tab_count >= TABLE_DEPTH) begin
				r.table_full = 1'b1;
			end else begin
				tab_ident[tab_count] = id;
				tab_addr[tab_count] = a;
				tab_port[tab_count] = '0;
				tab_count++;
			end
		end
		OP_REMOVE: begin
			for (i = 0; i < tab_count; i++)
				if (hit < 0 && tab_ident[i] == id)
					hit = i;
			if (hit >= 0) begin
				for (i = hit; i + 1 < tab_count; i++) begin
					tab_ident[i] = tab_ident[i + 1];
					tab_addr[i] = tab_addr[i + 1];
					tab_port[i] = tab_port[i + 1];
				end
				tab_count--;
			end
		end
		OP_CLEAR: begin
			tab_count = 0;
		end
		default: begin
			for (i = 0; i < tab_count; i++) begin
				if (hit < 0 && tab_addr[i] == a) begin
					if (tab_port[i] == p)
						hit = i;
					else if (tab_port[i] == 16'd0)
						free_idx = i;
				end
			end
			if (hit >= 0) begin
				r.allowed = 1'b1;
			end else if (free_idx >= 0) begin
				tab_port[free_idx] = p;
				r.allowed = 1'b1;
				r.bound_now = 1'b1;
			end
			r.private_addr = in_private_range(a);
			r.forward = r.allowed | r.private_addr;
		end
		endcase
		return r;
	endfunction

	task automatic send_word(op_t o, logic [31:0] id, logic [31:0] a, logic [15:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		player_id <= id;
		address <= a;
		port <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		verdict_q = {verdict_q, allowlist_apply(o, id, a, p)};
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t exp;
		string   field_name [5];
		field_name = '{"allowed", "bound_now", "private_addr", "forward", "table_full"};
		got = {allowed, bound_now, private_addr, forward, table_full};
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t unexpected result word: expected none, got %b", $time, got);
				fault_count++;
			end else begin
				exp = verdict_q.pop_front();
				for (int b = 0; b < 5; b++) begin
					if (got[4 - b] !== exp[4 - b]) begin
						$display("%0t %s: expected %b, got %b", $time, field_name[b],
							exp[4 - b], got[4 - b]);
						fault_count++;
					end
				end
			end
		end
	end

	function automatic logic [31:0] pool_addr();
		case ($urandom_range(9))
		0: return 32'h7F00_0001;
		1: return 32'h0A0A_0A0A;
		2: return 32'hAC1F_FFFF;
		3: return 32'hAC20_0001;
		4: return 32'hC0A8_0101;
		5: return 32'hC0A9_0101;
		6: return 32'h0808_0808;
		default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_table();
		send_word(OP_CHECK, 32'h0, 32'h0, 16'h0);
		send_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0);
		send_word(OP_CLEAR, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	task automatic test_port_learning();
		send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(OP_ADD, 32'h0, 32'h7F00_0001, 16'h0);
		send_word(OP_ADD, 32'd7, 32'h7F00_0001, 16'h0);
		send_word(OP_CHECK, 32'h0, 32'h7F00_0001, 16'd0);
		send_word(OP_CHECK, 32'h0, 32'h7F00_0001, 16'd1000);
		send_word(OP_CHECK, 32'h0, 32'h7F00_0001, 16'd2000);
		send_word(OP_CHECK, 32'h0, 32'h7F00_0001, 16'd3000);
		send_word(OP_CHECK, 32'h0, 32'h7F00_0001, 16'd1000);
		send_word(OP_CHECK, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(OP_CHECK, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	task automatic test_duplicate_remove();
		send_word(OP_ADD, 32'd7, 32'hC0A8_0001, 16'h0);
		send_word(OP_REMOVE, 32'd7, 32'h0, 16'h0);
		send_word(OP_CHECK, 32'h0, 32'hC0A8_0001, 16'd5);
		send_word(OP_REMOVE, 32'h1234_5678, 32'h0, 16'h0);
	endtask

	task automatic test_private_ranges();
		send_word(OP_CHECK, 32'h0, 32'h0A00_0000, 16'd1);
		send_word(OP_CHECK, 32'h0, 32'hAC1F_FFFF, 16'd1);
		send_word(OP_CHECK, 32'h0, 32'hAC0F_FFFF, 16'd1);
		send_word(OP_CHECK, 32'h0, 32'hC0A8_FFFF, 16'd1);
		send_word(OP_CHECK, 32'h0, 32'hC0A9_0000, 16'd1);
		send_word(OP_CHECK, 32'h0, 32'h8000_0000, 16'd1);
	endtask

	task automatic test_clear_all();
		send_word(OP_CLEAR, 32'h0, 32'h0, 16'h0);
		send_word(OP_CHECK, 32'h0, 32'h7F00_0001, 16'd1000);
	endtask

	task automatic test_random(int n);
		int sent;
		int r;
		logic [31:0] id;
		logic [31:0] a;
		logic [15:0] p;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(99);
			if (r < 33) begin
				id = ($urandom_range(1)) ? $urandom_range(7) : $urandom;
				send_word(OP_ADD, id, pool_addr(), 16'($urandom_range(65535)));
				sent++;
			end else if (r < 53) begin
				if (tab_count > 0 && $urandom_range(99) < 65)
					id = tab_ident[$urandom_range(tab_count - 1)];
				else
					id = ($urandom_range(1)) ? $urandom_range(7) : $urandom;
				send_word(OP_REMOVE, id, $urandom, 16'($urandom_range(65535)));
				sent++;
			end else if (r < 55) begin
				send_word(OP_CLEAR, $urandom, $urandom, 16'($urandom_range(65535)));
				sent++;
			end else if (r < 58) begin
				while (tab_count < TABLE_DEPTH) begin
					send_word(OP_ADD, $urandom_range(15), pool_addr(),
						16'($urandom_range(65535)));
					sent++;
				end
				send_word(OP_ADD, $urandom, $urandom, 16'($urandom_range(65535)));
				sent++;
			end else begin
				if (tab_count > 0 && $urandom_range(99) < 60)
					a = tab_addr[$urandom_range(tab_count - 1)];
				else
					a = pool_addr();
				r = $urandom_range(99);
				if (r < 15)
					p = 16'd0;
				else if (r < 40 && tab_count > 0)
					p = tab_port[$urandom_range(tab_count - 1)];
				else if (r < 75)
					p = 16'($urandom_range(1, 6));
				else
					p = 16'($urandom_range(65535));
				send_word(OP_CHECK, $urandom, a, p);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 30;
		recv_idle_pct = 56;
		test_empty_table();
		test_port_learning();
		test_duplicate_remove();
		test_private_ranges();
		test_clear_all();
		test_random(260);
		send_idle_pct = 56;
		recv_idle_pct = 30;
		test_random(270);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(270);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fault_count == 0)
			$display("client_allowlist_port_binding verification clean");
		else
			$display("client_allowlist_port_binding verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("client_allowlist_port_binding verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/capb_pkg.sv
rtl/capb_ram.sv
rtl/capb_queue.sv
rtl/capb_front.sv
rtl/capb_back.sv
rtl/client_allowlist_port_binding.sv
rtl/capb_checker.sv
dv/tb_top.sv
